// ----- rtl/dri_pkg.sv -----
// Shared constants, widths, structs and the arctangent table for the delta
// robot inverse kinematics block. No dependencies; every other file imports it.
package dri_pkg;

  localparam int FRAC_BITS    = 16;
  localparam int CORDIC_STEPS = 24;
  localparam int TAB_FRAC     = 24;

  localparam int CFG_W = 26;
  localparam int POS_W = 27;
  localparam int ANG_W = 25;
  localparam int ST_W  = 2;

  localparam int NUM_W = 57;
  localparam int MAG_W = 56;
  localparam int B_W   = 30;
  localparam int U_W   = 30;
  localparam int K_W   = 58;
  localparam int KS_W  = 31;
  localparam int P_W   = 2 * KS_W;
  localparam int SH_W  = 6;
  localparam int D_W   = 64;
  localparam int SQ_STEPS = 32;
  localparam int SQ_W  = 32;
  localparam int CX_W  = 38;
  localparam int CZ_W  = 33;
  localparam int T_W   = CZ_W + 2;

  localparam int LEG_LAT = MAG_W + SQ_STEPS + CORDIC_STEPS + 11;

  localparam int OSH = TAB_FRAC - FRAC_BITS;
  localparam int RND = (OSH > 0) ? (2 ** (OSH - 1)) : 0;
  localparam int ANG_LIM = 180 * (2 ** FRAC_BITS);

  localparam logic signed [31:0] SQRT3_Q30 = 32'sd1859775393;

  localparam logic [1:0] REG_UPPER_ARM = 2'd0;
  localparam logic [1:0] REG_LOWER_ARM = 2'd1;
  localparam logic [1:0] REG_BASE_RAD  = 2'd2;
  localparam logic [1:0] REG_PLAT_RAD  = 2'd3;

  localparam logic [CFG_W-1:0] RST_UPPER_ARM = CFG_W'(6553600);
  localparam logic [CFG_W-1:0] RST_LOWER_ARM = CFG_W'(13107200);
  localparam logic [CFG_W-1:0] RST_BASE_RAD  = CFG_W'(6553600);
  localparam logic [CFG_W-1:0] RST_PLAT_RAD  = CFG_W'(3276800);

  localparam logic [ST_W-1:0] ST_OK      = 2'd0;
  localparam logic [ST_W-1:0] ST_UNREACH = 2'd1;
  localparam logic [ST_W-1:0] ST_ZERO_K  = 2'd2;

  typedef struct packed {
    logic                    vld;
    logic signed [NUM_W-1:0] num;
    logic signed [B_W-1:0]   b;
    logic signed [U_W-1:0]   u;
  } leg_in_t;

  typedef struct packed {
    logic                    vld;
    logic [ST_W-1:0]         st;
    logic signed [ANG_W-1:0] ang;
  } leg_res_t;

  function automatic logic signed [CZ_W-1:0] atan_q24(input logic [4:0] idx);
    logic signed [CZ_W-1:0] v;
    case (idx)
      5'd0:  v = CZ_W'(754974720);
      5'd1:  v = CZ_W'(445687602);
      5'd2:  v = CZ_W'(235489088);
      5'd3:  v = CZ_W'(119537938);
      5'd4:  v = CZ_W'(60000934);
      5'd5:  v = CZ_W'(30029717);
      5'd6:  v = CZ_W'(15018523);
      5'd7:  v = CZ_W'(7509720);
      5'd8:  v = CZ_W'(3754917);
      5'd9:  v = CZ_W'(1877466);
      5'd10: v = CZ_W'(938734);
      5'd11: v = CZ_W'(469367);
      5'd12: v = CZ_W'(234684);
      5'd13: v = CZ_W'(117342);
      5'd14: v = CZ_W'(58671);
      5'd15: v = CZ_W'(29335);
      5'd16: v = CZ_W'(14668);
      5'd17: v = CZ_W'(7334);
      5'd18: v = CZ_W'(3667);
      5'd19: v = CZ_W'(1833);
      5'd20: v = CZ_W'(917);
      5'd21: v = CZ_W'(458);
      5'd22: v = CZ_W'(229);
      5'd23: v = CZ_W'(115);
      5'd24: v = CZ_W'(57);
      5'd25: v = CZ_W'(29);
      5'd26: v = CZ_W'(14);
      5'd27: v = CZ_W'(7);
      5'd28: v = CZ_W'(4);
      5'd29: v = CZ_W'(2);
      5'd30: v = CZ_W'(1);
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

// ----- rtl/dri_ifs.sv -----
// Handshake channels of the block: the position word in and the angle word out.
// Depends on dri_pkg for the field widths.
interface dri_pos_if import dri_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [POS_W-1:0] pos_x;
  logic signed [POS_W-1:0] pos_y;
  logic signed [POS_W-1:0] pos_z;
  modport source (output valid, pos_x, pos_y, pos_z, input ready);
  modport sink (input valid, pos_x, pos_y, pos_z, output ready);
endinterface

interface dri_ang_if import dri_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [ANG_W-1:0] angle_motor0;
  logic signed [ANG_W-1:0] angle_motor1;
  logic signed [ANG_W-1:0] angle_motor2;
  logic [ST_W-1:0]         solve_status;
  modport source (output valid, angle_motor0, angle_motor1, angle_motor2, solve_status,
                  input ready);
  modport sink (input valid, angle_motor0, angle_motor1, angle_motor2, solve_status,
                output ready);
endinterface

// ----- rtl/dri_leg.sv -----
// One leg solver: pipelined divider, quadratic setup, pipelined square root
// and pipelined CORDIC arctangent. Depends on dri_pkg.
module dri_leg import dri_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             adv_i,
  input  logic             half_i,
  input  logic [CFG_W-1:0] dv_i,
  input  leg_in_t          leg_i,
  output leg_res_t         res_o
);

  logic [LEG_LAT-1:0] vld_q;

  logic [CFG_W-1:0]        rem_q [MAG_W+1];
  logic [MAG_W-1:0]        nq_q  [MAG_W+1];
  logic                    ng_q  [MAG_W+1];
  logic signed [B_W-1:0]   bd_q  [MAG_W+1];
  logic signed [U_W-1:0]   ud_q  [MAG_W+1];
  logic [CFG_W-1:0]        rem_d [MAG_W];
  logic [MAG_W-1:0]        nq_d  [MAG_W];

  logic signed [K_W-1:0]   a1_d, a1_q;
  logic signed [B_W-1:0]   b1_q;
  logic signed [U_W-1:0]   u1_q;
  logic signed [K_W-1:0]   k2_q, v2_q;
  logic signed [U_W-1:0]   u2_q;
  logic [63:0]             m3_d, m3_q;
  logic signed [K_W-1:0]   k3_q, v3_q;
  logic signed [U_W-1:0]   u3_q;
  logic [7:0]              nz4_d, nz4_q;
  logic [3:0]              lb4_d [8];
  logic [3:0]              lb4_q [8];
  logic signed [K_W-1:0]   k4_q, v4_q;
  logic signed [U_W-1:0]   u4_q;
  logic [SH_W-1:0]         sh5_d, sh5_q;
  logic signed [K_W-1:0]   k5_q, v5_q;
  logic signed [U_W-1:0]   u5_q;
  logic signed [KS_W-1:0]  ks6_d, vs6_d, us6_d, ks6_q, vs6_q, us6_q;
  logic signed [P_W-1:0]   uu7_q, kv7_q;
  logic signed [KS_W-1:0]  k7_q, u7_q;
  logic                    kz7_q;

  logic signed [D_W-1:0]   d8_d;
  logic [ST_W-1:0]         st8_d;
  logic [D_W-1:0]          sv_q  [SQ_STEPS+1];
  logic [D_W-1:0]          sr_q  [SQ_STEPS+1];
  logic signed [KS_W-1:0]  sk_q  [SQ_STEPS+1];
  logic signed [KS_W-1:0]  su_q  [SQ_STEPS+1];
  logic [ST_W-1:0]         sst_q [SQ_STEPS+1];
  logic [D_W-1:0]          sv_d  [SQ_STEPS];
  logic [D_W-1:0]          sr_d  [SQ_STEPS];

  logic signed [CX_W-1:0]  cx0_d, cy0_d, den_d, num_d;
  logic signed [CX_W-1:0]  cx_q  [CORDIC_STEPS+1];
  logic signed [CX_W-1:0]  cy_q  [CORDIC_STEPS+1];
  logic signed [CZ_W-1:0]  cz_q  [CORDIC_STEPS+1];
  logic [ST_W-1:0]         cst_q [CORDIC_STEPS+1];
  logic signed [CX_W-1:0]  cx_d  [CORDIC_STEPS];
  logic signed [CX_W-1:0]  cy_d  [CORDIC_STEPS];
  logic signed [CZ_W-1:0]  cz_d  [CORDIC_STEPS];

  logic signed [T_W-1:0]   t_d, tr_d;
  logic signed [ANG_W-1:0] ang_d, ang_q;
  logic [ST_W-1:0]         st_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv_i) begin
      vld_q <= {vld_q[LEG_LAT-2:0], leg_i.vld};
    end
  end

  // Restoring division of the numerator magnitude, one quotient bit a stage.
  always_comb begin
    logic [CFG_W:0] trial;
    for (int j = 0; j < MAG_W; j++) begin
      trial = {rem_q[j], nq_q[j][MAG_W-1]};
      if (trial >= {1'b0, dv_i}) begin
        rem_d[j] = CFG_W'(trial - {1'b0, dv_i});
        nq_d[j]  = {nq_q[j][MAG_W-2:0], 1'b1};
      end else begin
        rem_d[j] = trial[CFG_W-1:0];
        nq_d[j]  = {nq_q[j][MAG_W-2:0], 1'b0};
      end
    end
  end

  always_comb begin
    logic [MAG_W-1:0] quo;
    quo  = half_i ? (nq_q[MAG_W] >> 1) : nq_q[MAG_W];
    a1_d = ng_q[MAG_W] ? -$signed({2'b00, quo}) : $signed({2'b00, quo});
  end

  always_comb begin
    logic [K_W-1:0] km, vm;
    logic [U_W-1:0] um;
    km   = k2_q[K_W-1] ? K_W'(-k2_q) : K_W'(k2_q);
    vm   = v2_q[K_W-1] ? K_W'(-v2_q) : K_W'(v2_q);
    um   = u2_q[U_W-1] ? U_W'(-u2_q) : U_W'(u2_q);
    m3_d = 64'(km) | 64'(vm) | 64'(um);
  end

  always_comb begin
    for (int c = 0; c < 8; c++) begin
      nz4_d[c] = |m3_q[8*c +: 8];
      lb4_d[c] = '0;
      for (int b = 0; b < 8; b++) begin
        if (m3_q[8*c + b]) begin
          lb4_d[c] = 4'(b + 1);
        end
      end
    end
  end

  // The shared shift brings all three coefficients to at most 2^30 in magnitude.
  always_comb begin
    logic [6:0] bl;
    bl = '0;
    for (int c = 0; c < 8; c++) begin
      if (nz4_q[c]) begin
        bl = 7'(8 * c) + 7'(lb4_q[c]);
      end
    end
    sh5_d = (bl > 7'd30) ? SH_W'(bl - 7'd30) : '0;
  end

  always_comb begin
    logic signed [K_W-1:0] kt, vt;
    logic signed [U_W-1:0] ut;
    kt    = k5_q >>> sh5_q;
    vt    = v5_q >>> sh5_q;
    ut    = u5_q >>> sh5_q;
    ks6_d = KS_W'(kt);
    vs6_d = KS_W'(vt);
    us6_d = KS_W'(ut);
  end

  always_comb begin
    d8_d = D_W'(uu7_q) - (D_W'(kv7_q) <<< 2);
    if (kz7_q) begin
      st8_d = ST_ZERO_K;
    end else if (d8_d < 0) begin
      st8_d = ST_UNREACH;
    end else begin
      st8_d = ST_OK;
    end
  end

  // Integer square root, two radicand bits a stage.
  always_comb begin
    logic [D_W-1:0] bt, tr;
    for (int i = 0; i < SQ_STEPS; i++) begin
      bt = D_W'(1) << (2 * (SQ_STEPS - 1 - i));
      tr = sr_q[i] + bt;
      if (sv_q[i] >= tr) begin
        sv_d[i] = sv_q[i] - tr;
        sr_d[i] = (sr_q[i] >> 1) + bt;
      end else begin
        sv_d[i] = sv_q[i];
        sr_d[i] = sr_q[i] >> 1;
      end
    end
  end

  always_comb begin
    logic [SQ_W-1:0] sq;
    sq    = sr_q[SQ_STEPS][SQ_W-1:0];
    num_d = -CX_W'(su_q[SQ_STEPS]) - CX_W'($signed({1'b0, sq}));
    den_d = CX_W'(sk_q[SQ_STEPS]) <<< 1;
    if (den_d < 0) begin
      cx0_d = -den_d;
      cy0_d = -num_d;
    end else begin
      cx0_d = den_d;
      cy0_d = num_d;
    end
  end

  always_comb begin
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      if (!cy_q[i][CX_W-1]) begin
        cx_d[i] = cx_q[i] + (cy_q[i] >>> i);
        cy_d[i] = cy_q[i] - (cx_q[i] >>> i);
        cz_d[i] = cz_q[i] + atan_q24(5'(i));
      end else begin
        cx_d[i] = cx_q[i] - (cy_q[i] >>> i);
        cy_d[i] = cy_q[i] + (cx_q[i] >>> i);
        cz_d[i] = cz_q[i] - atan_q24(5'(i));
      end
    end
  end

  always_comb begin
    t_d  = T_W'(cz_q[CORDIC_STEPS]) <<< 1;
    tr_d = (t_d + T_W'(RND)) >>> OSH;
    if (tr_d > T_W'(ANG_LIM)) begin
      tr_d = T_W'(ANG_LIM);
    end else if (tr_d < -T_W'(ANG_LIM)) begin
      tr_d = -T_W'(ANG_LIM);
    end
    ang_d = (cst_q[CORDIC_STEPS] == ST_OK) ? ANG_W'(tr_d) : '0;
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      rem_q[0] <= '0;
      nq_q[0]  <= leg_i.num[NUM_W-1] ? MAG_W'(-leg_i.num) : MAG_W'(leg_i.num);
      ng_q[0]  <= leg_i.num[NUM_W-1];
      bd_q[0]  <= leg_i.b;
      ud_q[0]  <= leg_i.u;
      for (int j = 0; j < MAG_W; j++) begin
        rem_q[j+1] <= rem_d[j];
        nq_q[j+1]  <= nq_d[j];
        ng_q[j+1]  <= ng_q[j];
        bd_q[j+1]  <= bd_q[j];
        ud_q[j+1]  <= ud_q[j];
      end

      a1_q <= a1_d;
      b1_q <= bd_q[MAG_W];
      u1_q <= ud_q[MAG_W];

      k2_q <= a1_q + K_W'(b1_q);
      v2_q <= a1_q - K_W'(b1_q);
      u2_q <= u1_q;

      m3_q <= m3_d;
      k3_q <= k2_q;
      v3_q <= v2_q;
      u3_q <= u2_q;

      nz4_q <= nz4_d;
      for (int c = 0; c < 8; c++) begin
        lb4_q[c] <= lb4_d[c];
      end
      k4_q <= k3_q;
      v4_q <= v3_q;
      u4_q <= u3_q;

      sh5_q <= sh5_d;
      k5_q  <= k4_q;
      v5_q  <= v4_q;
      u5_q  <= u4_q;

      ks6_q <= ks6_d;
      vs6_q <= vs6_d;
      us6_q <= us6_d;

      uu7_q <= us6_q * us6_q;
      kv7_q <= ks6_q * vs6_q;
      k7_q  <= ks6_q;
      u7_q  <= us6_q;
      kz7_q <= (ks6_q == '0);

      sv_q[0]  <= $unsigned(d8_d);
      sr_q[0]  <= '0;
      sk_q[0]  <= k7_q;
      su_q[0]  <= u7_q;
      sst_q[0] <= st8_d;
      for (int i = 0; i < SQ_STEPS; i++) begin
        sv_q[i+1]  <= sv_d[i];
        sr_q[i+1]  <= sr_d[i];
        sk_q[i+1]  <= sk_q[i];
        su_q[i+1]  <= su_q[i];
        sst_q[i+1] <= sst_q[i];
      end

      cx_q[0]  <= cx0_d;
      cy_q[0]  <= cy0_d;
      cz_q[0]  <= '0;
      cst_q[0] <= sst_q[SQ_STEPS];
      for (int i = 0; i < CORDIC_STEPS; i++) begin
        cx_q[i+1]  <= cx_d[i];
        cy_q[i+1]  <= cy_d[i];
        cz_q[i+1]  <= cz_d[i];
        cst_q[i+1] <= cst_q[i];
      end

      ang_q <= ang_d;
      st_q  <= cst_q[CORDIC_STEPS];
    end
  end

  assign res_o.vld = vld_q[LEG_LAT-1];
  assign res_o.st  = st_q;
  assign res_o.ang = ang_q;

endmodule

// ----- rtl/delta_robot_inverse_kinematics.sv -----
// Delta robot inverse kinematics, top level. Depends on dri_pkg, dri_ifs, dri_leg.
// An accepted position word passes through four setup stages, 123 leg stages (56
// divider, 32 square root and 24 CORDIC stages among them) and the output register
// on its way to its angle word. One word is accepted every cycle; a stall on the
// output freezes the whole pipeline. Reset clears all valid bits and loads the
// register defaults.
module delta_robot_inverse_kinematics import dri_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  dri_pos_if.sink          pos_i,
  dri_ang_if.source        ang_o,
  input  logic             cfg_we_i,
  input  logic [1:0]       cfg_idx_i,
  input  logic [CFG_W-1:0] cfg_data_i
);

  logic [CFG_W-1:0] l1_q, la_q, rb_q, rp_q;
  logic [CFG_W-1:0] dv;
  logic signed [POS_W-1:0] r;
  logic adv;

  logic [3:0] vld_q;

  logic [51:0]             l1sq_q, lasq_q;
  logic signed [53:0]      rsq_q;
  logic signed [POS_W-1:0] x1_q, z1_q;
  logic signed [53:0]      xx1_q, yy1_q, zz1_q, xr1_q;
  logic signed [58:0]      ys1_q;

  logic signed [58:0]      ysr;
  logic signed [27:0]      w;
  logic signed [NUM_W-1:0] s2_q, xr2_q;
  logic signed [28:0]      p1_2q, p2_2q;
  logic signed [POS_W-1:0] x2_q, z2_q;

  logic signed [NUM_W-1:0] s3_q, n0_3q;
  logic signed [55:0]      p1r_3q, p2r_3q;
  logic signed [28:0]      p1_3q, p2_3q;
  logic signed [POS_W-1:0] x3_q, z3_q;

  logic signed [NUM_W-1:0] num4_q [3];
  logic signed [B_W-1:0]   b4_q [3];
  logic signed [POS_W-1:0] z4_q;

  leg_in_t  leg_in  [3];
  leg_res_t leg_res [3];

  logic out_vld_q;
  logic signed [ANG_W-1:0] m0_q, m1_q, m2_q;
  logic [ST_W-1:0]         st_q, st_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      l1_q <= RST_UPPER_ARM;
      la_q <= RST_LOWER_ARM;
      rb_q <= RST_BASE_RAD;
      rp_q <= RST_PLAT_RAD;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_UPPER_ARM: l1_q <= cfg_data_i;
        REG_LOWER_ARM: la_q <= cfg_data_i;
        REG_BASE_RAD:  rb_q <= cfg_data_i;
        REG_PLAT_RAD:  rp_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign r   = $signed({1'b0, rb_q}) - $signed({1'b0, rp_q});
  assign dv  = (l1_q == '0) ? CFG_W'(1) : l1_q;
  assign adv = !out_vld_q || ang_o.ready;
  assign pos_i.ready = adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q     <= '0;
      out_vld_q <= 1'b0;
    end else if (adv) begin
      vld_q     <= {vld_q[2:0], pos_i.valid};
      out_vld_q <= leg_res[0].vld & leg_res[1].vld & leg_res[2].vld;
    end
  end

  always_ff @(posedge clk_i) begin
    l1sq_q <= l1_q * l1_q;
    lasq_q <= la_q * la_q;
    rsq_q  <= r * r;
  end

  assign ysr = ys1_q + (59'sd1 <<< 29);
  assign w   = $signed(ysr[57:30]);

  always_ff @(posedge clk_i) begin
    if (adv) begin
      x1_q  <= pos_i.pos_x;
      z1_q  <= pos_i.pos_z;
      xx1_q <= pos_i.pos_x * pos_i.pos_x;
      yy1_q <= pos_i.pos_y * pos_i.pos_y;
      zz1_q <= pos_i.pos_z * pos_i.pos_z;
      xr1_q <= pos_i.pos_x * r;
      ys1_q <= pos_i.pos_y * SQRT3_Q30;

      s2_q  <= NUM_W'(xx1_q) + NUM_W'(yy1_q) + NUM_W'(zz1_q)
             + NUM_W'($signed({1'b0, l1sq_q})) - NUM_W'($signed({1'b0, lasq_q}))
             + NUM_W'(rsq_q);
      xr2_q <= NUM_W'(xr1_q) <<< 1;
      p1_2q <= 29'(x1_q) - 29'(w);
      p2_2q <= 29'(x1_q) + 29'(w);
      x2_q  <= x1_q;
      z2_q  <= z1_q;

      s3_q   <= s2_q;
      n0_3q  <= s2_q - xr2_q;
      p1r_3q <= p1_2q * r;
      p2r_3q <= p2_2q * r;
      p1_3q  <= p1_2q;
      p2_3q  <= p2_2q;
      x3_q   <= x2_q;
      z3_q   <= z2_q;

      num4_q[0] <= n0_3q;
      num4_q[1] <= s3_q + NUM_W'(p1r_3q);
      num4_q[2] <= s3_q + NUM_W'(p2r_3q);
      b4_q[0]   <= B_W'(x3_q) - B_W'(r);
      b4_q[1]   <= -(B_W'(r) <<< 1) - B_W'(p1_3q);
      b4_q[2]   <= -(B_W'(r) <<< 1) - B_W'(p2_3q);
      z4_q      <= z3_q;
    end
  end

  always_comb begin
    for (int g = 0; g < 3; g++) begin
      leg_in[g].vld = vld_q[3];
      leg_in[g].num = num4_q[g];
      leg_in[g].b   = b4_q[g];
      leg_in[g].u   = (g == 0) ? (U_W'(z4_q) <<< 1) : (U_W'(z4_q) <<< 2);
    end
  end

  for (genvar g = 0; g < 3; g++) begin : g_leg
    dri_leg u_leg (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .adv_i  (adv),
      .half_i (g == 0),
      .dv_i   (dv),
      .leg_i  (leg_in[g]),
      .res_o  (leg_res[g])
    );
  end

  always_comb begin
    if (leg_res[0].st != ST_OK) begin
      st_d = leg_res[0].st;
    end else if (leg_res[1].st != ST_OK) begin
      st_d = leg_res[1].st;
    end else begin
      st_d = leg_res[2].st;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      m0_q <= leg_res[1].ang;
      m1_q <= leg_res[2].ang;
      m2_q <= leg_res[0].ang;
      st_q <= st_d;
    end
  end

  assign ang_o.valid        = out_vld_q;
  assign ang_o.angle_motor0 = m0_q;
  assign ang_o.angle_motor1 = m1_q;
  assign ang_o.angle_motor2 = m2_q;
  assign ang_o.solve_status = st_q;

endmodule
